@@ hdl/amsup_pkg.sv @@
// ============================================================================
// amsup_pkg - shared codes for the arm mode supervisor
// Mode, event, outcome and action encodings used by the RTL and its checker.
// ============================================================================
package amsup_pkg;

    // Operating modes (also the encoding of target_state and arm_mode)
    localparam logic [2:0] MODE_DISABLED = 3'd0;
    localparam logic [2:0] MODE_HOLD     = 3'd1;
    localparam logic [2:0] MODE_JOG      = 3'd2;
    localparam logic [2:0] MODE_PLANNED  = 3'd3;
    localparam logic [2:0] MODE_HOMING   = 3'd4;

    // Event kinds
    typedef enum logic [1:0] {
        EV_REQUEST = 2'd0,
        EV_STOP    = 2'd1,
        EV_RESET   = 2'd2,
        EV_HOMED   = 2'd3
    } t_event;

    // Outcome codes
    localparam logic [3:0] OC_CHANGED       = 4'd0;
    localparam logic [3:0] OC_ALREADY       = 4'd1;
    localparam logic [3:0] OC_HOME_STARTED  = 4'd2;
    localparam logic [3:0] OC_BUSY          = 4'd3;
    localparam logic [3:0] OC_UNKNOWN       = 4'd4;
    localparam logic [3:0] OC_LATCHED       = 4'd5;
    localparam logic [3:0] OC_INVALID       = 4'd6;
    localparam logic [3:0] OC_ACT_FAILED    = 4'd7;
    localparam logic [3:0] OC_STOP_DEFERRED = 4'd8;
    localparam logic [3:0] OC_STOP_DONE     = 4'd9;
    localparam logic [3:0] OC_STOP_CUT_FAIL = 4'd10;
    localparam logic [3:0] OC_RESET_DONE    = 4'd11;
    localparam logic [3:0] OC_RESET_FAILED  = 4'd12;
    localparam logic [3:0] OC_HOME_OK       = 4'd13;
    localparam logic [3:0] OC_HOME_FAILED   = 4'd14;

    // Actions used by a transition
    localparam logic [3:0] ACT_NONE       = 4'd0;
    localparam logic [3:0] ACT_ENABLE     = 4'd1;
    localparam logic [3:0] ACT_DISABLE    = 4'd2;
    localparam logic [3:0] ACT_ACTIVATE   = 4'd3;
    localparam logic [3:0] ACT_ENTER_JOG  = 4'd4;
    localparam logic [3:0] ACT_EXIT_JOG   = 4'd5;
    localparam logic [3:0] ACT_DEACTIVATE = 4'd6;
    localparam logic [3:0] ACT_HOME       = 4'd7;
    localparam logic [3:0] ACT_STOP       = 4'd8;
    localparam logic [3:0] ACT_CLEAR      = 4'd9;

    // One result transaction
    typedef struct packed {
        logic       success;
        logic [3:0] outcome_code;
        logic [2:0] arm_mode;
        logic [3:0] action_used;
    } t_result;

endpackage

@@ hdl/arm_mode_supervisor.sv @@
// ============================================================================
// arm_mode_supervisor - operating mode supervisor for a robot arm
// Tracks disabled / hold / jog / planned motion / homing and answers each
// event transaction with a success flag, outcome code, mode and action.
// ============================================================================
// Each input transaction is one event (mode request, emergency stop, fault
// reset, homing finished) plus a flag telling whether the external action
// tied to it succeeded. Every event yields exactly one result transaction,
// in order. The event is first held in the input register; once the result
// register is empty or being drained, the decision logic updates the mode,
// busy, pending-stop and stop-latch registers, loads the result register
// and raises o_valid. Throughput is one transaction per cycle while the
// downstream side does not stall; the decision depends on the state left by
// the previous event, and that state is registered together with the
// result, so back-to-back events see each other's effects. o_stall rises
// only when both the input and result registers are full and the
// downstream side is stalling.
// Rules: jog, planned motion and homing are entered from hold only; enabling
// is refused while the stop latch is set; stop and reset force disabled
// (a stop during homing is deferred until homing finishes); requests and
// resets during homing are answered busy; homing-finished while idle is
// ignored.
// ============================================================================
module arm_mode_supervisor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // event channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [2:0] i_target_state,
    input  logic       i_action_ok,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_success,
    output logic [3:0] o_outcome_code,
    output logic [2:0] o_arm_mode,
    output logic [3:0] o_action_used
);
    import amsup_pkg::*;

    // input register
    logic       r_in_valid;
    t_event     r_ev;
    logic [2:0] r_tgt;
    logic       r_ok;

    // supervisor state
    logic [2:0] r_mode, n_mode;
    logic       r_busy, n_busy;
    logic       r_pend, n_pend;
    logic       r_latch, n_latch;

    // result register
    logic       r_out_valid;
    t_result    r_res, n_res;

    logic       adv;
    logic       in_take;
    logic       go;
    logic [3:0] go_act;

    // Stage 1 advances when the result register is empty or being drained.
    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ev  <= t_event'(i_mode);
            r_tgt <= i_target_state;
            r_ok  <= i_action_ok;
        end
    end

    // Decision logic for the event held in the input register
    always_comb begin
        n_mode  = r_mode;
        n_busy  = r_busy;
        n_pend  = r_pend;
        n_latch = r_latch;
        n_res.success      = 1'b0;
        n_res.outcome_code = OC_INVALID;
        n_res.action_used  = ACT_NONE;
        go     = 1'b0;
        go_act = ACT_NONE;

        unique case (r_ev)
            EV_REQUEST: begin
                priority if (r_busy) begin
                    n_res.outcome_code = OC_BUSY;
                end else if (r_tgt > MODE_HOMING) begin
                    n_res.outcome_code = OC_UNKNOWN;
                end else if (r_tgt == r_mode) begin
                    n_res.success      = 1'b1;
                    n_res.outcome_code = OC_ALREADY;
                end else begin
                    unique case (r_mode)
                        MODE_DISABLED: begin
                            priority if (r_tgt != MODE_HOLD) begin
                                n_res.outcome_code = OC_INVALID;
                            end else if (r_latch) begin
                                n_res.outcome_code = OC_LATCHED;
                            end else begin
                                go     = 1'b1;
                                go_act = ACT_ENABLE;
                            end
                        end
                        MODE_HOLD: begin
                            unique case (r_tgt)
                                MODE_DISABLED: begin
                                    go     = 1'b1;
                                    go_act = ACT_DISABLE;
                                end
                                MODE_PLANNED: begin
                                    go     = 1'b1;
                                    go_act = ACT_ACTIVATE;
                                end
                                MODE_JOG: begin
                                    go     = 1'b1;
                                    go_act = ACT_ENTER_JOG;
                                end
                                default: begin
                                    // homing starts at once; outcome comes later
                                    n_busy             = 1'b1;
                                    n_mode             = MODE_HOMING;
                                    n_res.success      = 1'b1;
                                    n_res.outcome_code = OC_HOME_STARTED;
                                    n_res.action_used  = ACT_HOME;
                                end
                            endcase
                        end
                        MODE_JOG: begin
                            if (r_tgt == MODE_HOLD) begin
                                go     = 1'b1;
                                go_act = ACT_EXIT_JOG;
                            end
                        end
                        MODE_PLANNED: begin
                            if (r_tgt == MODE_HOLD) begin
                                go     = 1'b1;
                                go_act = ACT_DEACTIVATE;
                            end
                        end
                        default: begin
                            n_res.outcome_code = OC_INVALID;
                        end
                    endcase
                    if (go) begin
                        n_res.action_used = go_act;
                        if (r_ok) begin
                            n_mode             = r_tgt;
                            n_res.success      = 1'b1;
                            n_res.outcome_code = OC_CHANGED;
                        end else begin
                            n_res.outcome_code = OC_ACT_FAILED;
                        end
                    end
                end
            end
            EV_STOP: begin
                n_latch           = 1'b1;
                n_res.action_used = ACT_STOP;
                if (r_busy) begin
                    n_pend             = 1'b1;
                    n_res.success      = 1'b1;
                    n_res.outcome_code = OC_STOP_DEFERRED;
                end else begin
                    n_mode             = MODE_DISABLED;
                    n_res.success      = r_ok;
                    n_res.outcome_code = r_ok ? OC_STOP_DONE : OC_STOP_CUT_FAIL;
                end
            end
            EV_RESET: begin
                if (r_busy) begin
                    n_res.outcome_code = OC_BUSY;
                end else begin
                    if (r_ok) begin
                        n_latch = 1'b0;
                    end
                    n_mode             = MODE_DISABLED;
                    n_res.success      = r_ok;
                    n_res.outcome_code = r_ok ? OC_RESET_DONE : OC_RESET_FAILED;
                    n_res.action_used  = ACT_CLEAR;
                end
            end
            default: begin
                // homing finished; ignored when no homing is running
                if (r_busy) begin
                    n_busy            = 1'b0;
                    n_res.action_used = ACT_HOME;
                    if (r_pend) begin
                        n_pend             = 1'b0;
                        n_mode             = MODE_DISABLED;
                        n_res.outcome_code = OC_HOME_FAILED;
                    end else begin
                        n_mode             = MODE_HOLD;
                        n_res.success      = r_ok;
                        n_res.outcome_code = r_ok ? OC_HOME_OK : OC_HOME_FAILED;
                    end
                end
            end
        endcase

        n_res.arm_mode = n_mode;
    end

    // State and result update, once per event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DISABLED;
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_latch     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_mode      <= n_mode;
                r_busy      <= n_busy;
                r_pend      <= n_pend;
                r_latch     <= n_latch;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_success      = r_res.success;
    assign o_outcome_code = r_res.outcome_code;
    assign o_arm_mode     = r_res.arm_mode;
    assign o_action_used  = r_res.action_used;

endmodule

@@ hdl/amsup_checker.sv @@
// ============================================================================
// amsup_checker - port-level checks for the arm mode supervisor
// Watches the result channel and checks outcome/mode/action consistency.
// ============================================================================
module amsup_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_success,
    input logic [3:0] o_outcome_code,
    input logic [2:0] o_arm_mode,
    input logic [3:0] o_action_used
);
    import amsup_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_success)
            && $stable(o_outcome_code) && $stable(o_arm_mode)
            && $stable(o_action_used))
        else $error("result changed while stalled");

    // a deferred stop leaves the arm homing
    a_stop_defer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outcome_code == OC_STOP_DEFERRED |->
            o_success && o_arm_mode == MODE_HOMING && o_action_used == ACT_STOP)
        else $error("deferred stop with wrong mode or action");

    // a change reports success and the action taken
    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outcome_code == OC_CHANGED |->
            o_success && o_action_used != ACT_NONE && o_arm_mode != MODE_HOMING)
        else $error("change without action");

    // refusals use no action and do not succeed
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_outcome_code == OC_BUSY || o_outcome_code == OC_UNKNOWN
            || o_outcome_code == OC_LATCHED || o_outcome_code == OC_INVALID) |->
            !o_success && o_action_used == ACT_NONE)
        else $error("refusal with action or success");

    // stop and reset outcomes end in disabled
    a_forced_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_outcome_code == OC_STOP_DONE || o_outcome_code == OC_STOP_CUT_FAIL
            || o_outcome_code == OC_RESET_DONE || o_outcome_code == OC_RESET_FAILED) |->
            o_arm_mode == MODE_DISABLED)
        else $error("stop or reset left arm enabled");

endmodule

bind arm_mode_supervisor amsup_checker u_amsup_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_success      (o_success),
    .o_outcome_code (o_outcome_code),
    .o_arm_mode     (o_arm_mode),
    .o_action_used  (o_action_used)
);

@@ dv/arm_mode_supervisor_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// arm_mode_supervisor_test - self-checking bench for the arm mode supervisor
// Replays a short list of hand-picked events, then about 1900 random events.
// The random events are mostly legal mode walks. Every result is checked against
// an in-bench mode/latch tracker or a typed row, under several idle and stall mixes.
// ============================================================================
module arm_mode_supervisor_test;
    import amsup_pkg::*;

    localparam int RANDOM_PER_PHASE = 475;   // four phases, ~1900 events
    localparam int LONG_HOLD_CYCLES = 300;   // receiver hold-off to back up the pipe
    localparam int SETTLE_CYCLES    = 8;     // result pipeline latency plus margin

    // ------------------------------------------------------------------------
    // DUT hookup; every input is known from time zero
    // ------------------------------------------------------------------------
    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic       o_stall;
    logic [1:0] i_mode         = 2'd0;
    logic [2:0] i_target_state = 3'd0;
    logic       i_action_ok    = 1'b0;
    logic       o_valid;
    logic       i_stall        = 1'b0;
    logic       o_success;
    logic [3:0] o_outcome_code;
    logic [2:0] o_arm_mode;
    logic [3:0] o_action_used;

    arm_mode_supervisor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_target_state (i_target_state),
        .i_action_ok    (i_action_ok),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_success      (o_success),
        .o_outcome_code (o_outcome_code),
        .o_arm_mode     (o_arm_mode),
        .o_action_used  (o_action_used)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_result expected_verdicts[$];   // oldest first, one per accepted event
    int      error_count = 0;
    int      idle_pct    = 0;        // sender: chance of a gap per cycle
    int      stall_pct   = 0;        // receiver: chance of a stall per cycle
    bit      hold_armed  = 1'b0;     // driver asks for the one long hold-off
    bit      hold_done   = 1'b0;
    int      hold_left   = 0;

    // Tracked copy of the supervisor state
    logic [2:0] mode_q    = MODE_DISABLED;
    logic       busy_q    = 1'b0;
    logic       pend_q    = 1'b0;    // stop deferred until homing ends
    logic       latch_q   = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor: applies one event to the tracked state and returns the
    // result the supervisor must produce for it.
    // ------------------------------------------------------------------------
    task automatic arbitrate_event(input t_event ev, input logic [2:0] tgt,
                                   input logic ok, output t_result res);
        logic       res_ok;
        logic [3:0] code;
        logic [3:0] act;
        bit         needs_action;
        res_ok       = 1'b0;
        code         = OC_INVALID;
        act          = ACT_NONE;
        needs_action = 1'b0;
        case (ev)
            EV_REQUEST: begin
                if (busy_q) begin
                    code = OC_BUSY;
                end else if (tgt > MODE_HOMING) begin
                    code = OC_UNKNOWN;
                end else if (tgt == mode_q) begin
                    res_ok = 1'b1;
                    code   = OC_ALREADY;
                end else begin
                    case (mode_q)
                        MODE_DISABLED: begin
                            if (tgt != MODE_HOLD) begin
                                code = OC_INVALID;
                            end else if (latch_q) begin
                                code = OC_LATCHED;
                            end else begin
                                act          = ACT_ENABLE;
                                needs_action = 1'b1;
                            end
                        end
                        MODE_HOLD: begin
                            needs_action = 1'b1;
                            if (tgt == MODE_DISABLED) begin
                                act = ACT_DISABLE;
                            end else if (tgt == MODE_PLANNED) begin
                                act = ACT_ACTIVATE;
                            end else if (tgt == MODE_JOG) begin
                                act = ACT_ENTER_JOG;
                            end else begin
                                // homing starts at once; its outcome comes later
                                needs_action = 1'b0;
                                busy_q       = 1'b1;
                                mode_q       = MODE_HOMING;
                                res_ok       = 1'b1;
                                code         = OC_HOME_STARTED;
                                act          = ACT_HOME;
                            end
                        end
                        MODE_JOG: begin
                            if (tgt == MODE_HOLD) begin
                                act          = ACT_EXIT_JOG;
                                needs_action = 1'b1;
                            end
                        end
                        MODE_PLANNED: begin
                            if (tgt == MODE_HOLD) begin
                                act          = ACT_DEACTIVATE;
                                needs_action = 1'b1;
                            end
                        end
                        default: begin
                            code = OC_INVALID;
                        end
                    endcase
                    if (needs_action) begin
                        if (ok) begin
                            mode_q = tgt;
                            res_ok = 1'b1;
                            code   = OC_CHANGED;
                        end else begin
                            code = OC_ACT_FAILED;
                        end
                    end
                end
            end
            EV_STOP: begin
                latch_q = 1'b1;
                act     = ACT_STOP;
                if (busy_q) begin
                    pend_q = 1'b1;
                    res_ok = 1'b1;
                    code   = OC_STOP_DEFERRED;
                end else begin
                    mode_q = MODE_DISABLED;
                    res_ok = ok;
                    code   = ok ? OC_STOP_DONE : OC_STOP_CUT_FAIL;
                end
            end
            EV_RESET: begin
                if (busy_q) begin
                    code = OC_BUSY;
                end else begin
                    if (ok) latch_q = 1'b0;
                    mode_q = MODE_DISABLED;
                    res_ok = ok;
                    code   = ok ? OC_RESET_DONE : OC_RESET_FAILED;
                    act    = ACT_CLEAR;
                end
            end
            default: begin
                // homing finished; ignored unless homing is running
                if (busy_q) begin
                    busy_q = 1'b0;
                    act    = ACT_HOME;
                    if (pend_q) begin
                        pend_q = 1'b0;
                        mode_q = MODE_DISABLED;
                        code   = OC_HOME_FAILED;
                    end else begin
                        mode_q = MODE_HOLD;
                        res_ok = ok;
                        code   = ok ? OC_HOME_OK : OC_HOME_FAILED;
                    end
                end
            end
        endcase
        res = {res_ok, code, mode_q, act};
    endtask

    // ------------------------------------------------------------------------
    // Sender: called at a falling edge, returns at a falling edge. Gaps are
    // drawn before the transaction is offered; valid never looks at stall.
    // ------------------------------------------------------------------------
    task automatic send_event(input t_event ev, input logic [2:0] tgt,
                              input logic ok, input bit typed,
                              input t_result typed_res);
        t_result res;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= ev;
        i_target_state <= tgt;
        i_action_ok    <= ok;
        do @(posedge i_clk); while (o_stall);
        arbitrate_event(ev, tgt, ok, res);
        // hand-typed rows override the tracker's answer
        expected_verdicts.push_back(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    // Random event, biased toward legal walks from the tracked state
    task automatic pick_event(output t_event ev, output logic [2:0] tgt,
                              output logic ok);
        int roll;
        roll = $urandom_range(99);
        ok   = ($urandom_range(9) < 8);
        tgt  = 3'($urandom_range(7));
        ev   = t_event'(2'($urandom_range(3)));
        if (roll >= 25) begin   // below 25: pure noise
            if (busy_q) begin
                if (roll < 70)      ev = EV_HOMED;
                else if (roll < 82) ev = EV_STOP;
            end else if (latch_q && roll < 60) begin
                ev = EV_RESET;
            end else if (roll < 92) begin
                ev = EV_REQUEST;
                case (mode_q)
                    MODE_DISABLED: tgt = MODE_HOLD;
                    MODE_HOLD:     tgt = 3'($urandom_range(4));
                    default:       tgt = MODE_HOLD;
                endcase
            end else begin
                ev = EV_STOP;
            end
        end
    endtask

    // Sender holds off until every result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall: random, plus one long hold-off counted here
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_done) begin
            i_stall   <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: in-order compare at each accepted result transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_verdicts.size() == 0) begin
                $error("result with nothing outstanding: success %0d code %0d mode %0d act %0d",
                       o_success, o_outcome_code, o_arm_mode, o_action_used);
                error_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (o_success !== want.success) begin
                    $error("success: expected %0d, got %0d", want.success, o_success);
                    error_count++;
                end
                if (o_outcome_code !== want.outcome_code) begin
                    $error("outcome_code: expected %0d, got %0d",
                           want.outcome_code, o_outcome_code);
                    error_count++;
                end
                if (o_arm_mode !== want.arm_mode) begin
                    $error("arm_mode: expected %0d, got %0d", want.arm_mode, o_arm_mode);
                    error_count++;
                end
                if (o_action_used !== want.action_used) begin
                    $error("action_used: expected %0d, got %0d",
                           want.action_used, o_action_used);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed rows
    // ------------------------------------------------------------------------
    typedef struct {
        t_event     ev;
        logic [2:0] tgt;
        logic       ok;
        bit         typed;
        t_result    res;
    } t_stim_row;

    t_stim_row stim_rows[$];

    task automatic add_row(input t_event ev, input logic [2:0] tgt, input logic ok,
                           input bit typed, input t_result res);
        t_stim_row row;
        row.ev    = ev;
        row.tgt   = tgt;
        row.ok    = ok;
        row.typed = typed;
        row.res   = res;
        stim_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_event     ev;
        logic [2:0] tgt;
        logic       ok;
        int         phase;

        // Right after reset: idle homing report, bad target, same mode,
        // jog not from hold, failed then good enable.
        add_row(EV_HOMED,   MODE_DISABLED, 1'b0, 1, {1'b0, OC_INVALID, MODE_DISABLED, ACT_NONE});
        add_row(EV_REQUEST, 3'd7,          1'b1, 1, {1'b0, OC_UNKNOWN, MODE_DISABLED, ACT_NONE});
        add_row(EV_REQUEST, MODE_DISABLED, 1'b0, 1, {1'b1, OC_ALREADY, MODE_DISABLED, ACT_NONE});
        add_row(EV_REQUEST, MODE_JOG,      1'b1, 1, {1'b0, OC_INVALID, MODE_DISABLED, ACT_NONE});
        add_row(EV_REQUEST, MODE_HOLD,     1'b0, 1,
                {1'b0, OC_ACT_FAILED, MODE_DISABLED, ACT_ENABLE});
        add_row(EV_REQUEST, MODE_HOLD,     1'b1, 1, {1'b1, OC_CHANGED, MODE_HOLD, ACT_ENABLE});
        // Walk through every transition out of hold and back
        add_row(EV_REQUEST, MODE_DISABLED, 1'b0, 0, '0);
        add_row(EV_REQUEST, MODE_JOG,      1'b1, 0, '0);
        add_row(EV_REQUEST, MODE_PLANNED,  1'b1, 0, '0);   // jog -> planned refused
        add_row(EV_REQUEST, MODE_HOLD,     1'b1, 0, '0);
        add_row(EV_REQUEST, MODE_PLANNED,  1'b1, 0, '0);
        add_row(EV_REQUEST, MODE_HOLD,     1'b0, 0, '0);
        add_row(EV_REQUEST, MODE_HOLD,     1'b1, 0, '0);
        // Homing: busy refusals, deferred stop, aborted homing
        add_row(EV_REQUEST, MODE_HOMING,   1'b0, 0, '0);   // ok bit ignored
        add_row(EV_REQUEST, MODE_HOLD,     1'b1, 1, {1'b0, OC_BUSY, MODE_HOMING, ACT_NONE});
        add_row(EV_RESET,   MODE_DISABLED, 1'b1, 1, {1'b0, OC_BUSY, MODE_HOMING, ACT_NONE});
        add_row(EV_STOP,    MODE_DISABLED, 1'b0, 0, '0);
        add_row(EV_HOMED,   MODE_DISABLED, 1'b1, 0, '0);
        // Latch blocks enabling until a good reset
        add_row(EV_REQUEST, MODE_HOLD,     1'b1, 1, {1'b0, OC_LATCHED, MODE_DISABLED, ACT_NONE});
        add_row(EV_RESET,   MODE_DISABLED, 1'b0, 0, '0);
        add_row(EV_RESET,   MODE_DISABLED, 1'b1, 0, '0);
        add_row(EV_REQUEST, MODE_HOLD,     1'b1, 0, '0);
        add_row(EV_REQUEST, MODE_HOMING,   1'b1, 0, '0);
        add_row(EV_HOMED,   MODE_DISABLED, 1'b0, 0, '0);   // homing failed, back to hold
        // Stop from idle, torque cut failing then working
        add_row(EV_STOP,    MODE_DISABLED, 1'b0, 0, '0);
        add_row(EV_STOP,    MODE_HOLD,     1'b1, 0, '0);

        // Hold reset, then release it at a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[k])
            send_event(stim_rows[k].ev, stim_rows[k].tgt, stim_rows[k].ok,
                       stim_rows[k].typed, stim_rows[k].res);
        drain_results();

        // Random phases: free flow (with the long receiver hold-off),
        // sparse sender, heavy receiver stall, both moderately.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  hold_armed = 1'b1; end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                pick_event(ev, tgt, ok);
                send_event(ev, tgt, ok, 0, '0);
            end
            // sender pauses until the pipe is empty
            drain_results();
        end

        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_verdicts.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
